// ===== rtl/cnl_pkg.sv =====
// shared types, constants and codes for the count normalise / log / clr unit
// no dependencies; imported by every module of the block
package cnl_pkg;

    // front queue
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // unit latencies in register stages
    localparam int DIV_LAT = 47;
    localparam int LOG_LAT = 34;
    localparam int LOG_PAD = DIV_LAT - LOG_LAT;

    // ln 2 in q.24
    localparam logic [23:0] LN2_Q24 = 24'd11629080;

    localparam logic signed [47:0] VAL_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] VAL_MIN = 48'sh8000_0000_0000;

    localparam logic [1:0] METHOD_REL = 2'd1;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_METHOD = 2'd0,
        CFG_SCALE  = 2'd1,
        CFG_PSEUDO = 2'd2,
        CFG_DENSE  = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_SAT = 2'd1,
        ST_NEG = 2'd2
    } t_status;

    // work class decided by the front
    typedef enum logic [2:0] {
        OP_MARK,
        OP_CLR_ZERO,
        OP_CLR_SAT,
        OP_REL_SF0,
        OP_REL_DIV,
        OP_LOG,
        OP_LOG_SF0,
        OP_CLR_LOG
    } t_op;

    typedef struct packed {
        logic [1:0]  method;
        logic [31:0] scale;
        logic        pseudo;
        logic        dense;
    } t_cfg;

    // queue entry between front and back
    typedef struct packed {
        t_op         op;
        logic [30:0] row;
        logic [32:0] x;
        logic [31:0] sf;
    } t_entry;

    // data that rides alongside the arithmetic units
    typedef struct packed {
        t_op         op;
        logic [30:0] row;
        logic [31:0] v;
        logic        sat;
        logic        ovf;
    } t_meta;

    typedef struct packed {
        logic               kind;
        logic [30:0]        row;
        logic signed [47:0] val;
        t_status            status;
    } t_result;

endpackage

// ===== rtl/cnl_front.sv =====
// front: classifies incoming transactions and holds them in a short queue
// depends on cnl_pkg
module cnl_front import cnl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_push,
    output logic        o_full,
    input  logic        i_command,
    input  logic [31:0] i_sample_value,
    input  logic [31:0] i_size_factor,
    input  logic [30:0] i_row_index,
    output logic        o_q_valid,
    output t_entry      o_q_entry,
    input  logic        i_q_pop
);

    t_entry              n_ent;
    t_entry              r_q [QDEPTH];
    logic [QPTR_W-1:0]   r_wr;
    logic [QPTR_W-1:0]   r_rd;
    logic [QPTR_W:0]     r_cnt;
    logic                wr;
    logic                rd;

    // classify the item
    always_comb begin
        n_ent.row = i_row_index;
        n_ent.sf  = i_size_factor;
        n_ent.x   = {1'b0, i_sample_value};
        if (i_cfg.method[1] && i_cfg.pseudo) begin
            n_ent.x = {1'b0, i_sample_value} + 33'h1_0000;
        end
        if (i_command) begin
            n_ent.op = OP_MARK;
        end else if (i_cfg.method[1]) begin
            if (n_ent.x == 33'h0) begin
                n_ent.op = OP_CLR_ZERO;
            end else if (i_size_factor == 32'h0) begin
                n_ent.op = OP_CLR_SAT;
            end else begin
                n_ent.op = OP_CLR_LOG;
            end
        end else if (i_cfg.method == METHOD_REL) begin
            n_ent.op = (i_size_factor == 32'h0) ? OP_REL_SF0 : OP_REL_DIV;
        end else begin
            n_ent.op = (i_size_factor == 32'h0) ? OP_LOG_SF0 : OP_LOG;
        end
    end

    assign o_full    = (r_cnt == (QPTR_W+1)'(QDEPTH));
    assign wr        = i_push && !o_full;
    assign rd        = i_q_pop && (r_cnt != '0);
    assign o_q_valid = (r_cnt != '0);
    assign o_q_entry = r_q[r_rd];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wr] <= n_ent;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wr <= r_wr + 1'b1;
            end
            if (rd) begin
                r_rd <= r_rd + 1'b1;
            end
            if (wr && !rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd && !wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/cnl_log2.sv =====
// pipelined log2 of a 64-bit integer in q.32: normalise, then repeated squaring
// depends on cnl_pkg
module cnl_log2 import cnl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_n,
    output logic [37:0] o_log
);

    localparam int NSQ = LOG_LAT - 2;

    logic [63:0] r_n;
    logic [3:0]  r_nz;
    logic [3:0]  r_pos [4];
    logic [3:0]  n_pos [4];
    logic [5:0]  n_k;
    logic [95:0] sh;
    logic [31:0] r_m [NSQ+1];
    logic [5:0]  r_k [NSQ+1];
    logic [31:0] r_f [NSQ+1];
    logic [31:0] n_m [NSQ+1];
    logic [31:0] n_f [NSQ+1];
    logic [63:0] sq  [NSQ+1];

    // top set bit inside each 16-bit chunk
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            n_pos[c] = 4'h0;
            for (int b = 0; b < 16; b++) begin
                if (i_n[16*c+b]) begin
                    n_pos[c] = 4'(b);
                end
            end
        end
    end

    // pick the top chunk and align the mantissa to q1.31
    always_comb begin
        n_k = 6'h0;
        for (int c = 0; c < 4; c++) begin
            if (r_nz[c]) begin
                n_k = {2'(c), r_pos[c]};
            end
        end
        sh = {r_n, 32'h0} >> ({1'b0, n_k} + 7'd1);
    end

    // squaring steps, one fraction bit each
    always_comb begin
        n_m[0] = '0;
        n_f[0] = '0;
        sq[0]  = '0;
        for (int i = 1; i <= NSQ; i++) begin
            sq[i] = {32'h0, r_m[i-1]} * {32'h0, r_m[i-1]};
            if (sq[i][63]) begin
                n_m[i] = sq[i][63:32];
                n_f[i] = {r_f[i-1][30:0], 1'b1};
            end else begin
                n_m[i] = sq[i][62:31];
                n_f[i] = {r_f[i-1][30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n <= i_n;
            for (int c = 0; c < 4; c++) begin
                r_nz[c]  <= |i_n[16*c +: 16];
                r_pos[c] <= n_pos[c];
            end
            r_m[0] <= sh[31:0];
            r_k[0] <= n_k;
            r_f[0] <= '0;
            for (int i = 1; i <= NSQ; i++) begin
                r_m[i] <= n_m[i];
                r_f[i] <= n_f[i];
                r_k[i] <= r_k[i-1];
            end
        end
    end

    assign o_log = {r_k[NSQ], r_f[NSQ]};

endmodule

// ===== rtl/cnl_div.sv =====
// pipelined restoring divider, one quotient bit per stage
// depends on cnl_pkg
module cnl_div import cnl_pkg::*; (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [31:0]         i_rem,
    input  logic [DIV_LAT-1:0]  i_tail,
    input  logic [31:0]         i_sf,
    output logic [DIV_LAT-1:0]  o_quot
);

    logic [31:0]        r_r [DIV_LAT];
    logic [DIV_LAT-1:0] r_t [DIV_LAT];
    logic [DIV_LAT-1:0] r_q [DIV_LAT];
    logic [31:0]        r_d [DIV_LAT];
    logic [31:0]        n_r [DIV_LAT];
    logic [DIV_LAT-1:0] n_t [DIV_LAT];
    logic [DIV_LAT-1:0] n_q [DIV_LAT];
    logic [31:0]        pd  [DIV_LAT];
    logic [32:0]        rr  [DIV_LAT];

    // compare and subtract per stage
    always_comb begin
        for (int i = 0; i < DIV_LAT; i++) begin
            if (i == 0) begin
                rr[i]  = {i_rem, i_tail[DIV_LAT-1]};
                pd[i]  = i_sf;
                n_t[i] = {i_tail[DIV_LAT-2:0], 1'b0};
                n_q[i] = '0;
            end else begin
                rr[i]  = {r_r[i-1], r_t[i-1][DIV_LAT-1]};
                pd[i]  = r_d[i-1];
                n_t[i] = {r_t[i-1][DIV_LAT-2:0], 1'b0};
                n_q[i] = {r_q[i-1][DIV_LAT-2:0], 1'b0};
            end
            if (rr[i] >= {1'b0, pd[i]}) begin
                n_r[i]    = 32'(rr[i] - {1'b0, pd[i]});
                n_q[i][0] = 1'b1;
            end else begin
                n_r[i] = rr[i][31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < DIV_LAT; i++) begin
                r_r[i] <= n_r[i];
                r_t[i] <= n_t[i];
                r_q[i] <= n_q[i];
                r_d[i] <= pd[i];
            end
        end
    end

    assign o_quot = r_q[DIV_LAT-1];

endmodule

// ===== rtl/cnl_back.sv =====
// back: operand build, divider and log units, final select and result buffer
// depends on cnl_pkg, cnl_log2, cnl_div
module cnl_back import cnl_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_q_valid,
    input  t_entry             i_q_entry,
    output logic               o_q_pop,
    input  logic               i_pop,
    output logic               o_empty,
    output t_result            o_res
);

    logic               adv;
    logic               r_p1_v;
    t_entry             r_p1;
    logic               r_p2_v;
    t_entry             r_p2;
    logic [63:0]        r_p2_p;
    logic [64:0]        a65;
    logic [63:0]        w_a;
    logic [63:0]        w_b;
    t_meta              w_meta;
    logic [37:0]        la_out;
    logic [37:0]        lb_out;
    logic [DIV_LAT-1:0] quot;
    logic               r_mv [DIV_LAT];
    t_meta              r_md [DIV_LAT];
    logic [37:0]        r_la [LOG_PAD];
    logic [37:0]        r_lb [LOG_PAD];
    logic [38:0]        la;
    logic [38:0]        lb;
    logic [39:0]        dif;
    logic               r_d_v;
    t_meta              r_d_meta;
    logic [38:0]        r_d_mag;
    logic               r_d_neg;
    logic [DIV_LAT-1:0] r_d_q;
    logic               r_m_v;
    t_meta              r_m_meta;
    logic [62:0]        r_m_prod;
    logic               r_m_neg;
    logic [DIV_LAT-1:0] r_m_q;
    logic [62:0]        rnd;
    logic signed [47:0] logv;
    t_result            n_res;
    logic               n_keep;
    logic               is_clr;
    logic               r_r_v;
    t_result            r_r;
    t_result            r_ob [2];
    logic               r_owr;
    logic               r_ord;
    logic [1:0]         r_cnt;
    logic               owr;
    logic               ord;

    // whole pipeline moves while the result buffer has room
    assign adv     = (r_cnt != 2'd2);
    assign o_q_pop = adv && i_q_valid;

    // entry and scale product stages
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p1   <= i_q_entry;
            r_p2   <= r_p1;
            r_p2_p <= {32'h0, r_p1.x[31:0]} * {32'h0, i_cfg.scale};
        end
    end

    // operand build for the log units and divider
    always_comb begin
        a65 = {1'b0, r_p2_p} + {25'h0, r_p2.sf, 8'h0};
        w_meta.op  = r_p2.op;
        w_meta.row = r_p2.row;
        w_meta.v   = r_p2.x[31:0];
        w_meta.sat = (r_p2_p[63:31] >= {1'b0, r_p2.sf});
        w_meta.ovf = 1'b0;
        w_a = '0;
        w_b = '0;
        case (r_p2.op)
            OP_LOG: begin
                w_meta.ovf = a65[64];
                w_a = a65[64] ? a65[64:1] : a65[63:0];
                w_b = {24'h0, r_p2.sf, 8'h0};
            end
            OP_LOG_SF0: begin
                w_a = {31'h0, r_p2.x} + 64'h1_0000;
                w_b = 64'h1_0000;
            end
            OP_CLR_LOG: begin
                w_a = {31'h0, r_p2.x};
                w_b = {32'h0, r_p2.sf};
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    cnl_log2 u_la (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_n   (w_a),
        .o_log (la_out)
    );

    cnl_log2 u_lb (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_n   (w_b),
        .o_log (lb_out)
    );

    cnl_div u_div (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_rem  (r_p2_p[62:31]),
        .i_tail ({r_p2_p[30:0], 16'h0}),
        .i_sf   (r_p2.sf),
        .o_quot (quot)
    );

    // side data and log alignment delays
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_md[0] <= w_meta;
            for (int i = 1; i < DIV_LAT; i++) begin
                r_md[i] <= r_md[i-1];
            end
            r_la[0] <= la_out;
            r_lb[0] <= lb_out;
            for (int i = 1; i < LOG_PAD; i++) begin
                r_la[i] <= r_la[i-1];
                r_lb[i] <= r_lb[i-1];
            end
        end
    end

    // log difference
    always_comb begin
        la  = {1'b0, r_la[LOG_PAD-1]} + (r_md[DIV_LAT-1].ovf ? 39'h1_0000_0000 : 39'h0);
        lb  = {1'b0, r_lb[LOG_PAD-1]};
        dif = {1'b0, la} - {1'b0, lb};
    end

    // difference, scale by ln 2, round
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_d_meta <= r_md[DIV_LAT-1];
            r_d_neg  <= dif[39];
            r_d_mag  <= dif[39] ? 39'(-dif) : dif[38:0];
            r_d_q    <= quot;
            r_m_meta <= r_d_meta;
            r_m_neg  <= r_d_neg;
            r_m_q    <= r_d_q;
            r_m_prod <= {24'h0, r_d_mag} * {39'h0, LN2_Q24};
        end
    end

    // final value by class, and the zero drop
    always_comb begin
        rnd  = r_m_prod + 63'h8000_0000;
        logv = r_m_neg ? -$signed({17'h0, rnd[62:32]}) : $signed({17'h0, rnd[62:32]});
        n_res.kind   = 1'b0;
        n_res.row    = r_m_meta.row;
        n_res.val    = logv;
        n_res.status = ST_OK;
        is_clr       = 1'b0;
        case (r_m_meta.op)
            OP_MARK: begin
                n_res.kind = 1'b1;
                n_res.row  = '0;
                n_res.val  = '0;
            end
            OP_CLR_ZERO: begin
                n_res.val    = VAL_MIN;
                n_res.status = ST_NEG;
                is_clr       = 1'b1;
            end
            OP_CLR_SAT: begin
                n_res.val    = VAL_MAX;
                n_res.status = ST_SAT;
                is_clr       = 1'b1;
            end
            OP_CLR_LOG: begin
                is_clr = 1'b1;
            end
            OP_REL_SF0: begin
                n_res.val = $signed({8'h0, r_m_meta.v, 8'h0});
            end
            OP_REL_DIV: begin
                if (r_m_meta.sat) begin
                    n_res.val    = VAL_MAX;
                    n_res.status = ST_SAT;
                end else begin
                    n_res.val = $signed({1'b0, r_m_q});
                end
            end
            default: begin
                n_res.val = logv;
            end
        endcase
        n_keep = n_res.kind || (n_res.val != '0) || !(is_clr || i_cfg.dense);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_r <= n_res;
        end
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
            r_d_v  <= 1'b0;
            r_m_v  <= 1'b0;
            r_r_v  <= 1'b0;
            for (int i = 0; i < DIV_LAT; i++) begin
                r_mv[i] <= 1'b0;
            end
        end else if (adv) begin
            r_p1_v  <= i_q_valid;
            r_p2_v  <= r_p1_v;
            r_mv[0] <= r_p2_v;
            for (int i = 1; i < DIV_LAT; i++) begin
                r_mv[i] <= r_mv[i-1];
            end
            r_d_v <= r_mv[DIV_LAT-1];
            r_m_v <= r_d_v;
            r_r_v <= r_m_v && n_keep;
        end
    end

    // two-entry result buffer
    assign owr     = adv && r_r_v;
    assign ord     = i_pop && !o_empty;
    assign o_empty = (r_cnt == 2'd0);
    assign o_res   = r_ob[r_ord];

    always_ff @(posedge i_clk) begin
        if (owr) begin
            r_ob[r_owr] <= r_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owr <= 1'b0;
            r_ord <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (owr) begin
                r_owr <= ~r_owr;
            end
            if (ord) begin
                r_ord <= ~r_ord;
            end
            if (owr && !ord) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (ord && !owr) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    // buffer never holds more than two results
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result buffer count out of range");

    // a stalled pipeline keeps its last stage
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_r_v))
        else $error("last stage changed during stall");

    // log of non-positive always carries the most negative value
    a_neg_val: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_r_v && r_r.status == ST_NEG) |-> (r_r.val == VAL_MIN && !r_r.kind))
        else $error("bad value for non-positive log status");

endmodule

// ===== rtl/count_normalize_log_clr_unit.sv =====
// top level of the count normalise / log / clr unit: config registers, front, back
// depends on cnl_pkg, cnl_front, cnl_back
//
//   channel   direction  handshake          payload
//   input     in         push / full        i_command, i_sample_value, i_size_factor, i_row_index
//   result    out        empty / pop        o_entry_kind, o_out_row, o_result_value, o_status
//   config    in         i_cfg_we           i_cfg_idx, i_cfg_data
//
// one transaction accepted per cycle while full is low; items pass the entry and product stages,
// the 47-stage divider, the difference and ln 2 scaling stages and the result buffer
// synchronous active-low reset; no clearing pass, config registers return to defaults
// a full result buffer stalls the whole back pipeline; the 4-entry queue then fills
// and raises full; zero results that are dropped leave no gap in the output order
module count_normalize_log_clr_unit import cnl_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic               i_command,
    input  logic [31:0]        i_sample_value,
    input  logic [31:0]        i_size_factor,
    input  logic [30:0]        i_row_index,
    output logic               empty,
    input  logic               pop,
    output logic               o_entry_kind,
    output logic [30:0]        o_out_row,
    output logic signed [47:0] o_result_value,
    output logic [1:0]         o_status,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data
);

    t_cfg    r_cfg;
    logic    q_valid;
    t_entry  q_entry;
    logic    q_pop;
    t_result res;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.method <= 2'd0;
            r_cfg.scale  <= 32'd2560000;
            r_cfg.pseudo <= 1'b1;
            r_cfg.dense  <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_METHOD: r_cfg.method <= i_cfg_data[1:0];
                CFG_SCALE:  r_cfg.scale  <= i_cfg_data;
                CFG_PSEUDO: r_cfg.pseudo <= i_cfg_data[0];
                CFG_DENSE:  r_cfg.dense  <= i_cfg_data[0];
                default:    r_cfg        <= r_cfg;
            endcase
        end
    end

    cnl_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_push         (push),
        .o_full         (full),
        .i_command      (i_command),
        .i_sample_value (i_sample_value),
        .i_size_factor  (i_size_factor),
        .i_row_index    (i_row_index),
        .o_q_valid      (q_valid),
        .o_q_entry      (q_entry),
        .i_q_pop        (q_pop)
    );

    cnl_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_q_entry (q_entry),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_res     (res)
    );

    assign o_entry_kind   = res.kind;
    assign o_out_row      = res.row;
    assign o_result_value = res.val;
    assign o_status       = res.status;

endmodule

// ===== tb/sv/cnl_checker.sv =====
// checker for the count normalise / log / clr unit: watches every channel,
// predicts each result and compares it field by field
// depends on cnl_pkg
module cnl_checker import cnl_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    input  logic               full,
    input  logic               i_command,
    input  logic [31:0]        i_sample_value,
    input  logic [31:0]        i_size_factor,
    input  logic [30:0]        i_row_index,
    input  logic               empty,
    input  logic               pop,
    input  logic               o_entry_kind,
    input  logic [30:0]        o_out_row,
    input  logic signed [47:0] o_result_value,
    input  logic [1:0]         o_status,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    t_cfg    cfg;
    t_result awaited_results[$];

    // log2 of an integer in q.32, mantissa squared once per fraction bit
    function automatic logic [63:0] log2_fix(logic [63:0] n);
        int          k;
        logic [63:0] m;
        logic [31:0] frac;
        k = 63;
        frac = '0;
        if (n == 0) return '0;
        while (!n[k]) k--;
        m = (k >= 31) ? (n >> (k - 31)) : (n << (31 - k));
        for (int i = 0; i < 32; i++) begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'h1_0000_0000) begin
                frac[0] = 1'b1;
                m = m >> 1;
            end
        end
        return (64'(k) << 32) + 64'(frac);
    endfunction

    // ln(a/b) in q.24 from two log2 values, rounded half away from zero
    function automatic logic signed [63:0] ln_ratio(logic [63:0] la, logic [63:0] lb);
        logic signed [63:0] d;
        logic [63:0]        mag;
        logic [63:0]        r;
        d = la - lb;
        mag = d[63] ? -d : d;
        r = (mag * 64'(LN2_Q24) + (64'd1 << 31)) >> 32;
        return d[63] ? -$signed(r) : $signed(r);
    endfunction

    // expected result of one element or column end; keep low when it is dropped
    function automatic t_result normalize_entry(logic cmd, logic [31:0] v, logic [31:0] sf,
                                                logic [30:0] row, output bit keep);
        t_result            res;
        logic signed [63:0] val;
        t_status            st;
        logic [63:0]        p, q, rem, r, a, b, la;
        logic [64:0]        wide;
        bit                 clr;
        res = '0;
        keep = 1'b1;
        val = 0;
        st = ST_OK;
        clr = cfg.method[1];
        if (cmd) begin
            res.kind = 1'b1;
            return res;
        end
        if (clr) begin
            a = 64'(v) + (cfg.pseudo ? 64'h1_0000 : 64'd0);
            if (a == 0) begin
                val = VAL_MIN;
                st = ST_NEG;
            end else if (sf == 0) begin
                val = VAL_MAX;
                st = ST_SAT;
            end else begin
                val = ln_ratio(log2_fix(a), log2_fix(64'(sf)));
            end
        end else if (cfg.method == METHOD_REL) begin
            if (sf == 0) begin
                val = $signed(64'(v) << 8);
            end else begin
                p = 64'(v) * 64'(cfg.scale);
                q = p / 64'(sf);
                rem = p % 64'(sf);
                if (q >= 64'h8000_0000) begin
                    val = VAL_MAX;
                    st = ST_SAT;
                end else begin
                    r = (q << 16) + ((rem << 16) / 64'(sf));
                    if (r > 64'(VAL_MAX)) begin
                        val = VAL_MAX;
                        st = ST_SAT;
                    end else begin
                        val = $signed(r);
                    end
                end
            end
        end else begin
            if (sf == 0) begin
                val = ln_ratio(log2_fix(64'(v) + 64'h1_0000), log2_fix(64'h1_0000));
            end else begin
                p = 64'(v) * 64'(cfg.scale);
                b = 64'(sf) << 8;
                wide = 65'(p) + 65'(b);
                // a sum past 64 bits takes log2 of its upper 64 bits plus one
                if (wide[64]) la = log2_fix(wide[64:1]) + (64'd1 << 32);
                else la = log2_fix(wide[63:0]);
                val = ln_ratio(la, log2_fix(b));
            end
        end
        if (val == 0 && (clr || cfg.dense)) keep = 1'b0;
        res.row = row;
        res.val = val[47:0];
        res.status = st;
        return res;
    endfunction

    // watch config writes, accepted inputs and accepted results
    always @(posedge i_clk) begin
        t_result res;
        t_result exp_res;
        bit      keep;
        int      errs;
        errs = 0;
        if (!i_rst_n) begin
            cfg <= '{method: 2'd0, scale: 32'd2560000, pseudo: 1'b1, dense: 1'b0};
            o_fail_count <= 0;
            o_checked <= 0;
            awaited_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_METHOD: cfg.method <= i_cfg_data[1:0];
                    CFG_SCALE:  cfg.scale <= i_cfg_data;
                    CFG_PSEUDO: cfg.pseudo <= i_cfg_data[0];
                    CFG_DENSE:  cfg.dense <= i_cfg_data[0];
                    default:    ;
                endcase
            end
            if (push && !full) begin
                res = normalize_entry(i_command, i_sample_value, i_size_factor, i_row_index,
                                      keep);
                if (keep) awaited_results = {awaited_results, res};
            end
            if (pop && !empty) begin
                o_checked <= o_checked + 1;
                if (awaited_results.size() == 0) begin
                    $error("unexpected result transaction: kind %0d row %0d value %0d",
                           o_entry_kind, o_out_row, o_result_value);
                    errs++;
                end else begin
                    exp_res = awaited_results.pop_front();
                    if (o_entry_kind !== exp_res.kind) begin
                        $error("entry_kind: expected %0d, got %0d", exp_res.kind, o_entry_kind);
                        errs++;
                    end
                    if (o_out_row !== exp_res.row) begin
                        $error("out_row: expected %0d, got %0d", exp_res.row, o_out_row);
                        errs++;
                    end
                    if (o_result_value !== exp_res.val) begin
                        $error("result_value: expected %0d, got %0d",
                               exp_res.val, o_result_value);
                        errs++;
                    end
                    if (o_status !== exp_res.status) begin
                        $error("status: expected %0d, got %0d", exp_res.status, o_status);
                        errs++;
                    end
                end
            end
            o_fail_count <= o_fail_count + errs;
        end
        o_pending <= awaited_results.size();
    end

endmodule

// ===== tb/sv/tb.sv =====
// testbench top for count_normalize_log_clr_unit: clock, reset, stimulus, verdict
// depends on cnl_pkg, count_normalize_log_clr_unit and cnl_checker
module tb import cnl_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic               i_command = 1'b0;
    logic [31:0]        i_sample_value = '0;
    logic [31:0]        i_size_factor = '0;
    logic [30:0]        i_row_index = '0;
    logic               empty;
    logic               pop = 1'b0;
    logic               o_entry_kind;
    logic [30:0]        o_out_row;
    logic signed [47:0] o_result_value;
    logic [1:0]         o_status;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_idx = '0;
    logic [31:0]        i_cfg_data = '0;

    int fail_count;
    int pending;
    int checked;
    int items_sent = 0;
    bit calm = 1'b0;

    count_normalize_log_clr_unit u_dut (.*);

    cnl_checker u_checker (
        .*,
        .o_fail_count(fail_count),
        .o_pending(pending),
        .o_checked(checked)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // receiver: random stall bursts, none once the run is calm
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(negedge i_clk);
            if (calm) begin
                pop <= 1'b1;
            end else if (stall > 0) begin
                pop <= 1'b0;
                stall--;
            end else if ($urandom_range(0, 5) == 0) begin
                pop <= 1'b0;
                stall = $urandom_range(0, 6);
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // one input transaction, with an occasional idle burst ahead of it
    task automatic send_entry(logic cmd, logic [31:0] v, logic [31:0] sf, logic [30:0] row);
        if (!calm && $urandom_range(0, 5) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        push <= 1'b1;
        i_command <= cmd;
        i_sample_value <= v;
        i_size_factor <= sf;
        i_row_index <= row;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        @(negedge i_clk);
        items_sent++;
    endtask

    // drain every pending result, then let dropped entries clear the pipeline
    task automatic drain_block();
        push <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (70) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [31:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_mode(logic [1:0] method, logic [31:0] scale, logic pseudo, logic dense);
        drain_block();
        write_reg(CFG_METHOD, 32'(method));
        write_reg(CFG_SCALE, scale);
        write_reg(CFG_PSEUDO, 32'(pseudo));
        write_reg(CFG_DENSE, 32'(dense));
    endtask

    // counts and size factors biased towards zero, integers, tiny and extreme values
    function automatic logic [31:0] pick_q16();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(1, 300) << 16;
            3: return $urandom_range(1, 255);
            default: return $urandom;
        endcase
    endfunction

    // columns of entries sharing one size factor, closed by a column end
    task automatic random_columns(int n);
        logic [31:0] sf;
        int          left;
        left = n;
        while (left > 0) begin
            sf = pick_q16();
            repeat ($urandom_range(0, 12)) begin
                if ($urandom_range(0, 15) == 0) begin
                    send_entry(1'b0, pick_q16(), pick_q16(), 31'($urandom));
                end else begin
                    send_entry(1'b0, pick_q16(), sf, 31'($urandom));
                end
                left--;
            end
            send_entry(1'b1, $urandom, $urandom, 31'($urandom));
            left--;
        end
    endtask

    task automatic directed_set();
        send_entry(1'b0, 32'd0, 32'd0, 31'd0);
        send_entry(1'b0, 32'hFFFF_FFFF, 32'd0, 31'h7FFF_FFFF);
        send_entry(1'b0, 32'hFFFF_FFFF, 32'd1, 31'd5);
        send_entry(1'b0, 32'd1, 32'hFFFF_FFFF, 31'd6);
        send_entry(1'b0, 32'h0001_0000, 32'h0001_0000, 31'd7);
        send_entry(1'b0, 32'd0, 32'h0001_0000, 31'd8);
        send_entry(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
    endtask

    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: log mode, default scale
        directed_set();
        random_columns(200);

        set_mode(2'd0, 32'hFFFF_FFFF, 1'b1, 1'b1);
        directed_set();
        random_columns(200);

        set_mode(2'd1, 32'd1, 1'b0, 1'b0);
        directed_set();
        random_columns(200);

        set_mode(2'd1, 32'hFFFF_FFFF, 1'b1, 1'b1);
        directed_set();
        random_columns(200);

        // clr without pseudocount: zero count hits the log of zero
        set_mode(2'd2, 32'd2560000, 1'b0, 1'b0);
        directed_set();
        random_columns(200);

        // hold off until every result has arrived, then carry on
        drain_block();

        set_mode(2'd3, 32'd256, 1'b1, 1'b0);
        directed_set();
        random_columns(200);

        set_mode(2'd0, 32'd1, 1'b0, 1'b0);
        random_columns(200);

        set_mode(2'd2, 32'($urandom), 1'b1, 1'b1);
        calm = 1'b1;
        random_columns(250);

        drain_block();
        $display("sent %0d input transactions over eight register settings", items_sent);
        $display("checked %0d result transactions in log, relative and clr modes", checked);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/cnl_pkg.sv
rtl/cnl_front.sv
rtl/cnl_log2.sv
rtl/cnl_div.sv
rtl/cnl_back.sv
rtl/count_normalize_log_clr_unit.sv
tb/sv/cnl_checker.sv
tb/sv/tb.sv
